@@ rtl/orv_pkg.sv @@
// Shared types and constants for the optimal replacement eviction counter.
package orv_pkg;

  // Field widths fixed by the stream format.
  localparam int ID_W    = 8;
  localparam int COUNT_W = 8;
  localparam int CFG_W   = 5;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_CHK,
    S_SCAN,
    S_OUT
  } orv_state_t;

  // Control group broadcast from the sequencer to every slot cell.
  typedef struct packed {
    logic            seq_clr;    // empty all slots for the next sequence
    logic            wr_en;      // write wr_id into the selected cell
    logic            wr_victim;  // select by victim chain instead of fill pointer
    logic [ID_W-1:0] wr_id;
    logic [ID_W-1:0] key;        // id looked up for a hit
    logic            scan_clr;   // start of a look-ahead scan
    logic            scan_en;    // scan_id holds a valid future request
    logic [ID_W-1:0] scan_id;
  } orv_cell_ctl_t;

endpackage

@@ rtl/orv_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module orv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ rtl/orv_cell.sv @@
// One replacement slot: resident id, look-ahead mark and victim chain link.
module orv_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  orv_pkg::orv_cell_ctl_t ctl,
  input  logic                   fill_sel,
  input  logic                   lower_in,
  output logic                   lower_out,
  output logic                   hit,
  output logic                   unfound
);
  import orv_pkg::*;

  logic            valid_r, valid_nxt;
  logic            found_r, found_nxt;
  logic [ID_W-1:0] content_r;
  logic            victim;
  logic            wr;

  // A resident id not yet seen in the scan is a candidate; the lowest one wins.
  assign unfound   = valid_r & ~found_r;
  assign lower_out = lower_in | unfound;
  assign victim    = unfound & ~lower_in;
  assign hit       = valid_r && (content_r == ctl.key);
  assign wr        = ctl.wr_en & (ctl.wr_victim ? victim : fill_sel);

  // Next state of the valid and look-ahead marks.
  always_comb begin
    valid_nxt = valid_r;
    found_nxt = found_r;
    if (ctl.seq_clr) begin
      valid_nxt = 1'b0;
    end else if (wr) begin
      valid_nxt = 1'b1;
    end
    if (ctl.scan_clr) begin
      found_nxt = 1'b0;
    end else if (ctl.scan_en && valid_r && (content_r == ctl.scan_id)) begin
      found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      found_r <= found_nxt;
    end
  end

  // Resident id.
  always_ff @(posedge clk) begin
    if (wr) begin
      content_r <= ctl.wr_id;
    end
  end

endmodule

@@ rtl/optimal_replacement_evictions_core.sv @@
// Top level of the optimal (furthest next use) replacement eviction counter.
//
//   Channel  Dir  Beat contents                         Accepted when
//   in_      in   tdata[7:0] request_id, tlast last      in_tvalid & in_tready
//   out_     out  tdata[7:0] eviction_count,             out_tvalid & out_tready
//                 tuser overflowed
//   cfg_     in   wr_data[4:0] slots_in_use              cfg_wr_en
//
// Requests load at one beat per cycle while in_tready is high. After the beat
// with tlast the sequencer replays the stored sequence from the request memory:
// each request is read in S_RD and checked in S_CHK; a hit or a fill ends there,
// while an eviction moves on to S_SCAN, which reads the future requests in turn
// and stops once a single slot is left unseen or the sequence ends, then writes
// the victim. S_OUT hands the result to the output register. The request memory
// has a single read port. in_tready is low from the tlast beat until the result
// is moved into the output register. Reset is synchronous; a waiting result
// holds while out_tready is low and loading continues.
module optimal_replacement_evictions_core #(
  parameter int MAX_REQUESTS = 128,
  parameter int MAX_SLOTS    = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [orv_pkg::ID_W-1:0]     in_tdata,     // [7:0] request_id
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [orv_pkg::COUNT_W-1:0]  out_tdata,    // [7:0] eviction_count
  output logic                         out_tuser,    // [0] overflowed
  input  logic                         cfg_wr_en,
  input  logic [orv_pkg::CFG_W-1:0]    cfg_wr_data   // slots_in_use
);
  import orv_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int SW = $clog2(MAX_SLOTS + 1);

  orv_state_t       state_r, state_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    j_r, j_nxt;
  logic             pend_r, pend_nxt;
  logic             drop_r, drop_nxt;
  logic [COUNT_W-1:0] evict_r, evict_nxt;
  logic [SW-1:0]    filled_r, filled_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic             out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic             out_ovf_r;
  logic [ID_W-1:0]  new_id_r;
  logic             new_id_load;
  logic             out_load;

  logic             ram_we;
  logic [AW-1:0]    rd_addr;
  logic [ID_W-1:0]  rd_data;
  logic [SW-1:0]    cap;
  orv_cell_ctl_t    cell_ctl;
  logic [MAX_SLOTS-1:0] hit_v;
  logic [MAX_SLOTS-1:0] unf_v;
  logic [MAX_SLOTS:0]   chain;
  logic             hit_any;
  logic             one_left;
  logic             scan_done;
  logic             in_acc;

  assign in_acc     = in_tvalid & in_tready;
  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_ovf_r;

  // Request memory.
  orv_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Row of slot cells linked by the lowest-candidate chain.
  assign chain[0] = 1'b0;
  for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
    orv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .fill_sel  (filled_r == SW'(k)),
      .lower_in  (chain[k]),
      .lower_out (chain[k+1]),
      .hit       (hit_v[k]),
      .unfound   (unf_v[k])
    );
  end

  assign hit_any  = |hit_v;
  assign one_left = (unf_v != '0) && ((unf_v & (unf_v - MAX_SLOTS'(1))) == '0);
  assign scan_done = one_left || (!pend_r && (j_r >= total_r));

  // Effective slot count: zero acts as one, large values clamp.
  always_comb begin
    if (cfg_r == '0) begin
      cap = SW'(1);
    end else if (int'(cfg_r) > MAX_SLOTS) begin
      cap = SW'(MAX_SLOTS);
    end else begin
      cap = SW'(cfg_r);
    end
  end

  // Sequencer: next state, counters and cell controls.
  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    pend_nxt    = pend_r;
    drop_nxt    = drop_r;
    evict_nxt   = evict_r;
    filled_nxt  = filled_r;
    ram_we      = 1'b0;
    rd_addr     = i_r[AW-1:0];
    new_id_load = 1'b0;
    out_load    = 1'b0;
    cell_ctl           = '0;
    cell_ctl.key       = rd_data;
    cell_ctl.scan_id   = rd_data;
    cell_ctl.wr_id     = rd_data;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (total_r < CW'(MAX_REQUESTS)) begin
            ram_we    = 1'b1;
            total_nxt = total_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end

      S_RD: begin
        rd_addr   = i_r[AW-1:0];
        state_nxt = S_CHK;
      end

      S_CHK: begin
        if (hit_any || (filled_r < cap)) begin
          if (!hit_any) begin
            cell_ctl.wr_en = 1'b1;
            filled_nxt     = filled_r + SW'(1);
          end
          i_nxt     = i_r + CW'(1);
          state_nxt = ((i_r + CW'(1)) == total_r) ? S_OUT : S_RD;
        end else begin
          // All slots full: scan the future for the furthest next use.
          cell_ctl.scan_clr = 1'b1;
          new_id_load       = 1'b1;
          j_nxt             = i_r + CW'(1);
          pend_nxt          = 1'b0;
          state_nxt         = S_SCAN;
        end
      end

      S_SCAN: begin
        rd_addr = j_r[AW-1:0];
        if (scan_done) begin
          cell_ctl.wr_en     = 1'b1;
          cell_ctl.wr_victim = 1'b1;
          cell_ctl.wr_id     = new_id_r;
          evict_nxt          = evict_r + COUNT_W'(1);
          i_nxt              = i_r + CW'(1);
          state_nxt          = ((i_r + CW'(1)) == total_r) ? S_OUT : S_RD;
        end else begin
          cell_ctl.scan_en = pend_r;
          if (j_r < total_r) begin
            pend_nxt = 1'b1;
            j_nxt    = j_r + CW'(1);
          end else begin
            pend_nxt = 1'b0;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load         = 1'b1;
          cell_ctl.seq_clr = 1'b1;
          total_nxt        = '0;
          drop_nxt         = 1'b0;
          evict_nxt        = '0;
          filled_nxt       = '0;
          state_nxt        = S_LOAD;
        end
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      total_r     <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      drop_r      <= 1'b0;
      evict_r     <= '0;
      filled_r    <= '0;
      cfg_r       <= CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_r      <= pend_nxt;
      drop_r      <= drop_nxt;
      evict_r     <= evict_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (new_id_load) begin
      new_id_r <= rd_data;
    end
    if (out_load) begin
      out_count_r <= evict_r;
      out_ovf_r   <= drop_r;
    end
  end

endmodule

@@ rtl/orv_checker.sv @@
// Port-level checks for the eviction counter, bound to the top level.
module orv_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tlast,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [orv_pkg::COUNT_W-1:0] out_tdata,
  input logic                        out_tuser
);

  // A result waiting for the sink keeps its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // The final request of a sequence stops loading for the evaluation.
  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input accepted right after the final request");

  // A new result only appears at the end of an evaluation.
  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without an evaluation");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind optimal_replacement_evictions_core orv_checker u_orv_checker (.*);

@@ dv/eviction_checker.sv @@
`timescale 1ns / 100ps
// Checker module: rebuilds each request sequence, predicts its optimal eviction result and compares.
module eviction_checker #(
  parameter int MAX_REQUESTS = 128,
  parameter int MAX_SLOTS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [orv_pkg::ID_W-1:0]    in_tdata,
  input  logic                        in_tlast,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [orv_pkg::COUNT_W-1:0] out_tdata,
  input  logic                        out_tuser,
  input  logic                        cfg_wr_en,
  input  logic [orv_pkg::CFG_W-1:0]   cfg_wr_data,
  output int                          outstanding,
  output int                          mismatches
);
  import orv_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] eviction_count;
    logic               overflowed;
  } eviction_result_t;

  // Shadow of the sequence under load and of the slot count register.
  logic [ID_W-1:0]  seq_ids [MAX_REQUESTS];
  int unsigned      seq_len;
  bit               seq_dropped;
  logic [CFG_W-1:0] slots_reg;
  eviction_result_t due_results [$];
  int               fail_count = 0;

  // Replays the stored sequence with furthest-next-use replacement and counts evictions.
  function automatic int unsigned optimal_evictions();
    logic [ID_W-1:0] resident [MAX_SLOTS];
    int unsigned cap, filled, evicted, victim, furthest, next_at;
    int unsigned i, s, p;
    bit hit;
    cap = slots_reg;
    if (cap < 1) cap = 1;
    if (cap > MAX_SLOTS) cap = MAX_SLOTS;
    filled  = 0;
    evicted = 0;
    for (i = 0; i < seq_len; i++) begin
      hit = 1'b0;
      for (s = 0; s < filled; s++) begin
        if (resident[s] == seq_ids[i]) hit = 1'b1;
      end
      if (hit) continue;
      if (filled < cap) begin
        resident[filled] = seq_ids[i];
        filled++;
        continue;
      end
      // A line never requested again sits past the end (seq_len + 1); strict compare keeps the lowest slot.
      victim   = 0;
      furthest = 0;
      for (s = 0; s < filled; s++) begin
        next_at = seq_len + 1;
        for (p = i + 1; p < seq_len; p++) begin
          if (seq_ids[p] == resident[s]) begin
            next_at = p;
            break;
          end
        end
        if (s == 0 || next_at > furthest) begin
          furthest = next_at;
          victim   = s;
        end
      end
      resident[victim] = seq_ids[i];
      evicted++;
    end
    return evicted;
  endfunction

  // Watch all three ports on each rising edge; everything sampled here is the pre-edge value.
  always @(posedge clk) begin : watch
    eviction_result_t want;
    if (!rst_n) begin
      slots_reg   = CFG_W'(1);
      seq_len     = 0;
      seq_dropped = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_wr_en) slots_reg = cfg_wr_data;

      // Request beat: store it, or mark the sequence as overflowed once the store is full.
      if (in_tvalid && in_tready) begin
        if (seq_len < MAX_REQUESTS) begin
          seq_ids[seq_len] = in_tdata;
          seq_len++;
        end else begin
          seq_dropped = 1'b1;
        end
        if (in_tlast) begin
          want.eviction_count = COUNT_W'(optimal_evictions());
          want.overflowed     = seq_dropped;
          due_results.insert(due_results.size(), want);
          seq_len     = 0;
          seq_dropped = 1'b0;
        end
      end

      // Result beat: compare against the oldest predicted result.
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result beat: eviction_count %0d, overflowed %0b",
                 out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_tdata !== want.eviction_count) begin
            $error("eviction_count: expected %0d, actual %0d", want.eviction_count, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.overflowed) begin
            $error("overflowed: expected %0b, actual %0b", want.overflowed, out_tuser);
            fail_count++;
          end
        end
      end
    end
    outstanding <= due_results.size();
    mismatches  <= fail_count;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the optimal replacement eviction counter: clock, reset, stimulus and verdict.
module tb_top;
  import orv_pkg::*;

  localparam int MAX_REQ         = 128;
  localparam int TARGET_REQUESTS = 1200;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 300;
  localparam int LIMIT_CYCLES    = 1500000;

  // Slot counts for the first random phases: out-of-range high, minimum, just over, two, full.
  localparam logic [CFG_W-1:0] SLOT_SWEEP [5] = '{5'd31, 5'd1, 5'd17, 5'd2, 5'd16};

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [ID_W-1:0]    in_tdata    = '0;   // [7:0] request_id
  logic               in_tlast    = 1'b0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [COUNT_W-1:0] out_tdata;          // [7:0] eviction_count
  logic               out_tuser;          // [0] overflowed
  logic               cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data = '0;
  int                 outstanding;
  int                 mismatches;

  int unsigned cycle_count = 0;
  int unsigned hold_req    = 0;     // bumped to ask the result side for one long hold-off
  bit          calm        = 1'b0;  // no idling on either side
  bit          gaps_on     = 1'b0;  // request side may idle within the current sequence
  int unsigned stored      = 0;     // requests that landed in the store

  optimal_replacement_evictions_core dut (.*);

  eviction_checker u_eviction_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request, none in the closing part.
  initial begin : result_sink
    int unsigned holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one request beat, maybe after a gap, and return at the edge that takes it.
  task automatic send_request(input logic [ID_W-1:0] id, input logic last);
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // One sequence; a zero alphabet draws ids over the whole range.
  task automatic send_sequence(input int unsigned len, input int unsigned alphabet,
                               input logic [ID_W-1:0] base);
    logic [ID_W-1:0] id;
    int unsigned k;
    gaps_on = ($urandom_range(0, 3) != 0);
    for (k = 0; k < len; k++) begin
      if (alphabet == 0) id = ID_W'($urandom_range(0, 255));
      else id = ID_W'(base + $urandom_range(0, alphabet - 1));
      send_request(id, k == len - 1);
      if (k < MAX_REQ) stored++;
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned k, s, phase, seq_no, n_seq, len, alpha, eff;
    logic [CFG_W-1:0] slots_pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset slot count of one: every miss after the first evicts.
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b1);
    // A sequence of a single request.
    send_request(8'hFF, 1'b1);
    wait_idle();

    // A zero slot count behaves as one slot.
    write_slots(5'd0);
    send_request(8'h01, 1'b0);
    send_request(8'h02, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h03, 1'b1);
    wait_idle();

    // All sixteen slots, then one more line: no line comes back, so the tie goes to slot 0.
    write_slots(5'd16);
    for (k = 0; k <= 16; k++) send_request(ID_W'(k * 15), k == 16);
    wait_idle();
    stored = 25;

    // Random phases: one slot setting each, several sequences, then drain before the next write.
    phase  = 0;
    seq_no = 0;
    while (stored < TARGET_REQUESTS) begin
      slots_pick = (phase < 5) ? SLOT_SWEEP[phase] : CFG_W'($urandom_range(0, 31));
      eff = (slots_pick == 0) ? 1 : ((slots_pick > 16) ? 16 : slots_pick);
      write_slots(slots_pick);
      if (phase == 3) hold_req <= hold_req + 1;
      if (stored + 100 >= TARGET_REQUESTS) calm <= 1'b1;
      n_seq = (phase == 3) ? 5 : $urandom_range(2, 8);
      for (s = 0; s < n_seq; s++) begin
        seq_no++;
        // Short sequences under the hold-off, so finished results back up into the input.
        if (phase == 3) len = $urandom_range(6, 12);
        else if (seq_no % 15 == 0) len = $urandom_range(129, 140);
        else if (seq_no % 15 == 7) len = MAX_REQ;
        else if ($urandom_range(0, 9) == 0) len = $urandom_range(25, 127);
        else len = $urandom_range(1, 24);
        // Mostly a small alphabet around the slot count for hits and evictions.
        if ($urandom_range(0, 7) == 0) alpha = 0;
        else alpha = $urandom_range(1, eff + 6);
        send_sequence(len, alpha, ID_W'($urandom_range(0, 255)));
      end
      wait_idle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/orv_pkg.sv
rtl/orv_ram.sv
rtl/orv_cell.sv
rtl/optimal_replacement_evictions_core.sv
rtl/orv_checker.sv
dv/eviction_checker.sv
dv/tb_top.sv
